// File: rtl/i2af_pkg.sv
// ----------------------------------------------------------------------------
// i2af_pkg
// Shared types, constants and helpers of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package i2af_pkg;

   localparam int KIND_WIDTH   = 2;
   localparam int VALUE_WIDTH  = 64;
   localparam int CHAR_WIDTH   = 8;
   localparam int BIN_WIDTH    = 32;
   localparam int BCD_DIGITS   = 10;
   localparam int NIBBLE       = 4;
   localparam int BCD_WIDTH    = BCD_DIGITS * NIBBLE;
   localparam int MAX_DIGITS   = VALUE_WIDTH / NIBBLE;
   localparam int CNT_WIDTH    = $clog2(MAX_DIGITS + 1);
   localparam int SHIFT_WIDTH  = $clog2(BIN_WIDTH + 1);

   localparam logic [KIND_WIDTH-1:0] KIND_SDEC = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_UDEC = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_HEXL = 2'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_HEXU = 2'd3;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER = 8'h41;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_CONV,
      TOP_SEND
   } top_state_type;

   typedef enum logic [1:0] {
      SER_IDLE,
      SER_SKIP,
      SER_SEND
   } ser_state_type;

   typedef struct packed {
      logic                   valid;
      logic [VALUE_WIDTH-1:0] digits;
      logic [CNT_WIDTH-1:0]   count;
      logic                   minus;
      logic                   upper;
   } ser_load_type;

   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [NIBBLE-1:0] d,
                                                        input logic upper);
      logic [CHAR_WIDTH-1:0] base;
      base = upper ? CHAR_UPPER : CHAR_LOWER;
      if (d < 4'd10) begin
         digit_char = CHAR_ZERO + {4'd0, d};
      end else begin
         digit_char = base + {4'd0, d} - 8'd10;
      end
   endfunction

endpackage

// File: rtl/integer_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Formats one integer per word as ASCII text, one character per result word.
//
// The req channel takes the number in req_tdata and the format in req_tuser:
// signed decimal, unsigned decimal, lower-case or upper-case hexadecimal.
// The rsp channel returns the characters most significant first, with no
// leading zeros, a leading minus sign for negative signed values, and
// rsp_tlast on the final character.
// Decimal words run through a bit-serial binary to BCD converter; hexadecimal
// words skip it. Leading zeros are dropped one digit per cycle, then one
// character leaves per cycle while the receiver is ready.
// One word is worked on at a time; req_tready is high only while idle. The
// next word is accepted while the final character still waits in the output
// register. When rsp_tready is low the output register holds its character
// and the digit shifter waits. Reset empties the output and returns to idle.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [i2af_pkg::VALUE_WIDTH-1:0]   req_tdata,  // value
   input  logic [i2af_pkg::KIND_WIDTH-1:0]    req_tuser,  // kind
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [i2af_pkg::CHAR_WIDTH-1:0]    rsp_tdata,  // ascii_char
   output logic                               rsp_tlast
);
   import i2af_pkg::*;

   top_state_type         state_ff, state_in;
   logic                  minus_ff, minus_in;
   logic                  accept;
   logic [BIN_WIDTH-1:0]  low;
   logic                  neg;
   logic [BIN_WIDTH-1:0]  mag;
   logic                  bcd_start;
   logic                  bcd_done;
   logic [BCD_WIDTH-1:0]  bcd;
   logic                  ser_busy;
   ser_load_type          load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TOP_IDLE;
         minus_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         minus_ff <= minus_in;
      end
   end

   assign req_tready = (state_ff == TOP_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign low        = req_tdata[BIN_WIDTH-1:0];
   assign neg        = (req_tuser == KIND_SDEC) && low[BIN_WIDTH-1];
   assign mag        = neg ? (~low + BIN_WIDTH'(1)) : low;

   always_comb begin
      state_in    = state_ff;
      minus_in    = minus_ff;
      bcd_start   = 1'b0;
      load.valid  = 1'b0;
      load.digits = {bcd, {(VALUE_WIDTH-BCD_WIDTH){1'b0}}};
      load.count  = CNT_WIDTH'(BCD_DIGITS);
      load.minus  = minus_ff;
      load.upper  = 1'b0;
      unique case (state_ff)
         TOP_IDLE: begin
            if (accept) begin
               if (req_tuser == KIND_HEXL || req_tuser == KIND_HEXU) begin
                  load.valid  = 1'b1;
                  load.digits = req_tdata;
                  load.count  = CNT_WIDTH'(MAX_DIGITS);
                  load.minus  = 1'b0;
                  load.upper  = (req_tuser == KIND_HEXU);
                  state_in    = TOP_SEND;
               end else begin
                  bcd_start = 1'b1;
                  minus_in  = neg;
                  state_in  = TOP_CONV;
               end
            end
         end
         TOP_CONV: begin
            if (bcd_done) begin
               load.valid = 1'b1;
               state_in   = TOP_SEND;
            end
         end
         TOP_SEND: begin
            if (!ser_busy) begin
               state_in = TOP_IDLE;
            end
         end
         default: begin
            state_in = TOP_IDLE;
         end
      endcase
   end

   i2af_bcd u_bcd (
      .clock (clock),
      .reset (reset),
      .start (bcd_start),
      .bin   (mag),
      .done  (bcd_done),
      .bcd   (bcd)
   );

   i2af_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .busy       (ser_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: rtl/i2af_bcd.sv
// ----------------------------------------------------------------------------
// i2af_bcd
// Bit-serial binary to BCD converter: shifts in one binary bit per cycle and
// corrects each BCD digit by add-three before the shift.
// ----------------------------------------------------------------------------
module i2af_bcd (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [i2af_pkg::BIN_WIDTH-1:0]   bin,
   output logic                             done,
   output logic [i2af_pkg::BCD_WIDTH-1:0]   bcd
);
   import i2af_pkg::*;

   logic [BIN_WIDTH-1:0]   bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [SHIFT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic [BCD_WIDTH-1:0]   adj;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[i*NIBBLE +: NIBBLE] >= 4'd5) begin
            adj[i*NIBBLE +: NIBBLE] = bcd_ff[i*NIBBLE +: NIBBLE] + 4'd3;
         end else begin
            adj[i*NIBBLE +: NIBBLE] = bcd_ff[i*NIBBLE +: NIBBLE];
         end
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done    = busy_ff && (cnt_ff == '0);
      if (start) begin
         bin_in  = bin;
         bcd_in  = '0;
         cnt_in  = SHIFT_WIDTH'(BIN_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            bcd_in = {adj[BCD_WIDTH-2:0], bin_ff[BIN_WIDTH-1]};
            bin_in = {bin_ff[BIN_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   assign bcd = bcd_ff;

endmodule

// File: rtl/i2af_serializer.sv
// ----------------------------------------------------------------------------
// i2af_serializer
// Digit shift register that drops leading zeros one digit per cycle and then
// sends one character per word through a registered output stage.
// ----------------------------------------------------------------------------
module i2af_serializer (
   input  logic                              clock,
   input  logic                              reset,
   input  i2af_pkg::ser_load_type            load,
   output logic                              busy,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [i2af_pkg::CHAR_WIDTH-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);
   import i2af_pkg::*;

   ser_state_type          state_ff, state_in;
   logic [VALUE_WIDTH-1:0] dig_ff, dig_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   minus_ff, minus_in;
   logic                   upper_ff, upper_in;
   logic                   vld_ff, vld_in;
   logic [CHAR_WIDTH-1:0]  char_ff, char_in;
   logic                   last_ff, last_in;
   logic                   out_free;
   logic [NIBBLE-1:0]      top_digit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SER_IDLE;
         vld_ff   <= 1'b0;
         minus_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         minus_ff <= minus_in;
         cnt_ff   <= cnt_in;
      end
      dig_ff   <= dig_in;
      upper_ff <= upper_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   assign top_digit = dig_ff[VALUE_WIDTH-1 -: NIBBLE];
   assign out_free  = !vld_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      dig_in   = dig_ff;
      cnt_in   = cnt_ff;
      minus_in = minus_ff;
      upper_in = upper_ff;
      vld_in   = vld_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (vld_ff && rsp_tready) begin
         vld_in = 1'b0;
      end
      unique case (state_ff)
         SER_IDLE: begin
            if (load.valid) begin
               dig_in   = load.digits;
               cnt_in   = load.count;
               minus_in = load.minus;
               upper_in = load.upper;
               state_in = SER_SKIP;
            end
         end
         SER_SKIP: begin
            if (top_digit == '0 && cnt_ff > CNT_WIDTH'(1)) begin
               dig_in = {dig_ff[VALUE_WIDTH-NIBBLE-1:0], {NIBBLE{1'b0}}};
               cnt_in = cnt_ff - 1'b1;
            end else begin
               state_in = SER_SEND;
            end
         end
         SER_SEND: begin
            if (out_free) begin
               vld_in = 1'b1;
               if (minus_ff) begin
                  char_in  = CHAR_MINUS;
                  last_in  = 1'b0;
                  minus_in = 1'b0;
               end else begin
                  char_in = digit_char(top_digit, upper_ff);
                  last_in = (cnt_ff == CNT_WIDTH'(1));
                  dig_in  = {dig_ff[VALUE_WIDTH-NIBBLE-1:0], {NIBBLE{1'b0}}};
                  cnt_in  = cnt_ff - 1'b1;
                  if (cnt_ff == CNT_WIDTH'(1)) begin
                     state_in = SER_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = SER_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != SER_IDLE);
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = last_ff;

endmodule

// File: rtl/i2af_checker.sv
// ----------------------------------------------------------------------------
// i2af_checker
// Port-level checks of the integer to ASCII formatter, bound to the top level.
// ----------------------------------------------------------------------------
module i2af_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [i2af_pkg::CHAR_WIDTH-1:0]   rsp_tdata,
   input logic                              rsp_tlast
);
   import i2af_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("Stalled result word changed.");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("A second word was taken while one is in progress.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >= 8'h30 && rsp_tdata <= 8'h39) ||
                     (rsp_tdata >= 8'h61 && rsp_tdata <= 8'h66) ||
                     (rsp_tdata >= 8'h41 && rsp_tdata <= 8'h46) ||
                     (rsp_tdata == CHAR_MINUS))
      else $error("Result character is not a digit, hex letter or minus sign.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata == CHAR_MINUS |-> !rsp_tlast)
      else $error("A minus sign was marked as the final character.");

endmodule

bind integer_to_ascii_formatter_core i2af_checker u_i2af_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// File: sim/i2af_text_checker.sv
// ----------------------------------------------------------------------------
// i2af_text_checker
// Watches both channels of the integer to ASCII formatter. Every number that
// is accepted is turned into its expected characters. Every character word
// that leaves is compared with the oldest expected character.
// ----------------------------------------------------------------------------
module i2af_text_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [i2af_pkg::VALUE_WIDTH-1:0]   req_tdata,   // value
   input  logic [i2af_pkg::KIND_WIDTH-1:0]    req_tuser,   // kind
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [i2af_pkg::CHAR_WIDTH-1:0]    rsp_tdata,   // ascii_char
   input  logic                               rsp_tlast,
   output int                                 mismatch_count,
   output int                                 chars_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import i2af_pkg::*;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] code;
      logic                  last;
   } text_char_type;

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO    = "0";
   localparam logic [CHAR_WIDTH-1:0] ASCII_DASH    = "-";
   localparam logic [CHAR_WIDTH-1:0] ASCII_LOWER_A = "a";
   localparam logic [CHAR_WIDTH-1:0] ASCII_UPPER_A = "A";

   text_char_type expected_text[$];
   int            error_tally = 0;

   function automatic void predict_text(input logic [KIND_WIDTH-1:0] kind,
                                        input logic [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] mag;
      logic [VALUE_WIDTH-1:0] radix;
      logic [31:0]            neg_low;
      logic [3:0]             digit;
      logic [CHAR_WIDTH-1:0]  rev [16];
      text_char_type          item;
      int                     n;
      n = 0;
      radix = 64'd16;
      mag = value;
      if (kind == KIND_SDEC || kind == KIND_UDEC) begin
         radix = 64'd10;
         mag = {32'd0, value[31:0]};
         if (kind == KIND_SDEC && value[31]) begin
            neg_low = ~value[31:0] + 32'd1;
            mag = {32'd0, neg_low};
            item.code = ASCII_DASH;
            item.last = 1'b0;
            expected_text.push_back(item);
         end
      end
      do begin
         digit = 4'(mag % radix);
         if (digit < 4'd10) begin
            rev[n] = ASCII_ZERO + {4'd0, digit};
         end else begin
            rev[n] = ((kind == KIND_HEXU) ? ASCII_UPPER_A : ASCII_LOWER_A)
                     + {4'd0, digit} - 8'd10;
         end
         mag = mag / radix;
         n++;
      end while (mag != 0 && n < 16);
      for (int i = n - 1; i >= 0; i--) begin
         item.code = rev[i];
         item.last = (i == 0);
         expected_text.push_back(item);
      end
   endfunction

   function automatic void report(input string msg);
      error_tally++;
      if (error_tally <= 10) begin
         $display("%s", msg);
      end
   endfunction

   always @(posedge clock) begin
      text_char_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_text.size() == 0) begin
               report($sformatf("unexpected character %h last %b with nothing pending",
                                rsp_tdata, rsp_tlast));
            end else begin
               want = expected_text.pop_front();
               if (rsp_tdata !== want.code || rsp_tlast !== want.last) begin
                  report($sformatf("mismatch: expected char %h last %b, got char %h last %b",
                                   want.code, want.last, rsp_tdata, rsp_tlast));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_text(req_tuser, req_tdata);
         end
      end
      mismatch_count <= error_tally;
      chars_pending <= expected_text.size();
   end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the integer to ASCII formatter. A directed set of numbers
// covers the extremes of every format, followed by random numbers of varied
// magnitude, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import i2af_pkg::*;

   localparam int IDLE_LIMIT   = 3000;
   localparam int RANDOM_WORDS = 450;
   localparam int QUIET_FROM   = 400;
   localparam int DIRECTED     = 22;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [VALUE_WIDTH-1:0] req_tdata  = '0;
   logic [KIND_WIDTH-1:0]  req_tuser  = KIND_SDEC;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [CHAR_WIDTH-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   int                     mismatch_count;
   int                     chars_pending;
   bit                     quiet_tail = 1'b0;
   int                     idle_cycles = 0;

   logic [KIND_WIDTH-1:0] dir_kind [DIRECTED] = '{
      KIND_SDEC, KIND_SDEC, KIND_SDEC, KIND_SDEC, KIND_SDEC, KIND_SDEC, KIND_SDEC,
      KIND_UDEC, KIND_UDEC, KIND_UDEC, KIND_UDEC, KIND_UDEC,
      KIND_HEXL, KIND_HEXL, KIND_HEXL, KIND_HEXL, KIND_HEXL,
      KIND_HEXU, KIND_HEXU, KIND_HEXU, KIND_HEXU, KIND_HEXU
   };
   logic [VALUE_WIDTH-1:0] dir_value [DIRECTED] = '{
      64'h0, 64'h1, 64'hFFFF_FFFF, 64'h8000_0000, 64'h7FFF_FFFF,
      64'hDEAD_BEEF_0000_0005, 64'hFFFF_FFFF_8000_0000,
      64'h0, 64'hFFFF_FFFF, 64'd10, 64'd9, 64'h1234_5678_0000_002A,
      64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF, 64'h1,
      64'h8000_0000_0000_0000,
      64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFEDC_BA98_7654_3210, 64'hA,
      64'hFFFF_FFFF_0000_0000
   };

   integer_to_ascii_formatter_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   i2af_text_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .chars_pending  (chars_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic send_number(input logic [KIND_WIDTH-1:0] kind,
                              input logic [VALUE_WIDTH-1:0] value);
      int gap;
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tuser <= kind;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      int span;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            span = $urandom_range(1, 4);
            rsp_tready <= 1'b0;
         end else begin
            span = $urandom_range(1, 8);
            rsp_tready <= 1'b1;
         end
         repeat (span) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [KIND_WIDTH-1:0]  kind;
      logic [VALUE_WIDTH-1:0] value;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < DIRECTED; i++) begin
         send_number(dir_kind[i], dir_value[i]);
      end
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i >= QUIET_FROM) begin
            quiet_tail = 1'b1;
         end
         kind = KIND_WIDTH'($urandom_range(0, 3));
         value = {$urandom, $urandom};
         case ($urandom_range(0, 4))
            0: value = value >> $urandom_range(0, 63);
            1: value = 64'($urandom_range(0, 20));
            2: value = {value[63:32], 32'hFFFF_FFFF - 32'($urandom_range(0, 20))};
            3: value = {value[63:32], 32'(64'd1 << $urandom_range(0, 31))};
            default: ;
         endcase
         send_number(kind, value);
      end
      req_tvalid <= 1'b0;
      do @(posedge clock); while (chars_pending != 0);
      repeat (60) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/i2af_pkg.sv
rtl/i2af_bcd.sv
rtl/i2af_serializer.sv
rtl/integer_to_ascii_formatter_core.sv
rtl/i2af_checker.sv
sim/i2af_text_checker.sv
sim/tb_top.sv
